@@ sv/spg_pkg.sv @@
package spg_pkg;

    localparam int DIV_W     = 32;
    localparam int RPM_W     = 16;
    localparam int PERIOD_W  = 16;
    localparam int PULSE_W   = 17;
    localparam int POS_W     = 32;
    localparam int STEPS_W   = 18;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_RPM_DEFAULT     = 1000;
    localparam int MOTOR_STEPS_DEFAULT = 200;

    localparam int TIMER_HZ       = 1000000;
    localparam int SECONDS_PER_MIN = 60;

    // rpm times steps per revolution fits in RATE_PROD_W bits; the scaled
    // reciprocal gives the exact floor of the division by 60 over that range
    localparam int RATE_PROD_W = 29;
    localparam int RECIP_W     = 30;
    localparam int RECIP_SHIFT = 35;
    localparam logic [RECIP_W-1:0] RATE_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SECONDS_PER_MIN) - 64'd1)
                 / 64'(SECONDS_PER_MIN));

    localparam logic [PERIOD_W-1:0] PERIOD_MAX     = 16'hFFFF;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN     = 16'd10;
    localparam logic [PERIOD_W-1:0] PERIOD_DEFAULT = 16'd100;

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SET_POS = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_RPM     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVER_ENABLE = 4'd1;

    typedef struct packed {
        logic take;
        logic div_start;
        logic period_default;
        logic period_quot;
    } ctrl_cmd_t;

    typedef struct packed {
        logic speed_wr;
        logic rpm_ok;
        logic rate_zero;
        logic div_done;
    } dp_status_t;

endpackage

@@ sv/spg_div.sv @@
module spg_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [spg_pkg::DIV_W-1:0] dividend,
    input  logic [spg_pkg::DIV_W-1:0] divisor,
    output logic                      done,
    output logic [spg_pkg::DIV_W-1:0] quotient
);
    import spg_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DIV_W:0]   shifted;
    logic [DIV_W+1:0] diff;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign ge      = !diff[DIV_W+1];

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/spg_datapath.sv @@
module spg_datapath #(
    parameter int MAX_RPM     = spg_pkg::MAX_RPM_DEFAULT,
    parameter int MOTOR_STEPS = spg_pkg::MOTOR_STEPS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [spg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [spg_pkg::CMD_W-1:0]           cmd,
    input  logic signed [spg_pkg::STEPS_W-1:0]  steps,
    input  logic                                direction,
    input  logic signed [spg_pkg::POS_W-1:0]    new_position,
    input  spg_pkg::ctrl_cmd_t                  ctl,
    output spg_pkg::dp_status_t                 st,
    output logic                                step_level,
    output logic                                dir_level,
    output logic                                enable_level,
    output logic                                busy_res,
    output logic signed [spg_pkg::POS_W-1:0]    position
);
    import spg_pkg::*;

    localparam int SCALED_W = RATE_PROD_W + RECIP_W;

    logic                  cfg_wr;
    logic [RPM_W-1:0]      rpm_reg;
    logic                  enable_reg;
    logic [PERIOD_W-1:0]   period_reg, period_next;

    logic [PERIOD_W-1:0]   tick_reg, tick_next;
    logic [PULSE_W-1:0]    pulses_reg, pulses_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  dir_reg, dir_next;
    logic                  run_reg, run_next;
    logic                  step_reg, step_next;

    logic [RATE_PROD_W-1:0] prod_reg, prod_next;
    logic [SCALED_W-1:0]    scaled;
    logic [DIV_W-1:0]       rate_reg, rate_next;
    logic [DIV_W-1:0]       div_quot;
    logic                   div_done;

    logic [STEPS_W-1:0]    raw;
    logic [STEPS_W-1:0]    mag_abs;
    logic [PULSE_W-1:0]    mag;
    logic [PERIOD_W:0]     tick_inc;
    logic [PULSE_W-1:0]    pulses_dec;

    assign cfg_wr = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_reg    <= '0;
            enable_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == REG_SPEED_RPM)
                rpm_reg <= cfg_data[RPM_W-1:0];
            if (cfg_index == REG_DRIVER_ENABLE)
                enable_reg <= cfg_data[0];
        end
    end

    assign prod_next = RATE_PROD_W'(rpm_reg) * RATE_PROD_W'(MOTOR_STEPS);
    assign scaled    = SCALED_W'(prod_reg) * SCALED_W'(RATE_RECIP);
    assign rate_next = DIV_W'(scaled >> RECIP_SHIFT);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rate_reg <= rate_next;
    end

    spg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (DIV_W'(TIMER_HZ)),
        .divisor  (rate_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign st.speed_wr  = cfg_wr && (cfg_index == REG_SPEED_RPM);
    assign st.rpm_ok    = (rpm_reg != '0) && (32'(rpm_reg) <= 32'(MAX_RPM));
    assign st.rate_zero = (rate_reg == '0);
    assign st.div_done  = div_done;

    always_comb
    begin
        period_next = period_reg;
        if (ctl.period_default)
            period_next = PERIOD_DEFAULT;
        else if (ctl.period_quot)
        begin
            if (div_quot > DIV_W'(PERIOD_MAX))
                period_next = PERIOD_MAX;
            else if (div_quot < DIV_W'(PERIOD_MIN))
                period_next = PERIOD_MIN;
            else
                period_next = div_quot[PERIOD_W-1:0];
        end
    end

    assign raw        = steps;
    assign mag_abs    = raw[STEPS_W-1] ? (~raw + 1'b1) : raw;
    assign mag        = mag_abs[STEPS_W-1] ? '1 : mag_abs[PULSE_W-1:0];
    assign tick_inc   = {1'b0, tick_reg} + 1'b1;
    assign pulses_dec = pulses_reg - 1'b1;

    always_comb
    begin
        tick_next   = tick_reg;
        pulses_next = pulses_reg;
        pos_next    = pos_reg;
        dir_next    = dir_reg;
        run_next    = run_reg;
        unique case (cmd)
            CMD_TICK:
            begin
                if (run_reg)
                begin
                    if (tick_inc > {1'b0, period_reg})
                    begin
                        tick_next   = '0;
                        pulses_next = pulses_dec;
                        if (pulses_dec == '0)
                            run_next = 1'b0;
                    end
                    else
                        tick_next = tick_inc[PERIOD_W-1:0];
                end
            end
            CMD_MOVE:
            begin
                if (!run_reg && (mag != '0))
                begin
                    dir_next    = direction;
                    pos_next    = direction ? (pos_reg + POS_W'(mag))
                                            : (pos_reg - POS_W'(mag));
                    pulses_next = mag;
                    tick_next   = '0;
                    run_next    = 1'b1;
                end
            end
            CMD_STOP:
            begin
                run_next    = 1'b0;
                pulses_next = '0;
                tick_next   = '0;
            end
            CMD_SET_POS:
            begin
                pos_next = new_position;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
        step_next = run_next && (tick_next < (period_reg >> 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_DEFAULT;
            tick_reg   <= '0;
            pulses_reg <= '0;
            pos_reg    <= '0;
            dir_reg    <= 1'b0;
            run_reg    <= 1'b0;
            step_reg   <= 1'b0;
        end
        else
        begin
            period_reg <= period_next;
            if (ctl.take)
            begin
                tick_reg   <= tick_next;
                pulses_reg <= pulses_next;
                pos_reg    <= pos_next;
                dir_reg    <= dir_next;
                run_reg    <= run_next;
                step_reg   <= step_next;
            end
        end
    end

    assign step_level   = step_reg;
    assign dir_level    = dir_reg;
    assign enable_level = enable_reg;
    assign busy_res     = run_reg;
    assign position     = $signed(pos_reg);

endmodule

@@ sv/spg_ctrl.sv @@
module spg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  spg_pkg::dp_status_t st,
    output spg_pkg::ctrl_cmd_t  ctl
);
    import spg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RATE,
        S_RATE_CHK,
        S_PERIOD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_blocked;

    assign out_blocked = out_valid_reg && out_stall;
    assign in_stall    = (state_reg != S_IDLE) || st.speed_wr || out_blocked;

    always_comb
    begin
        ctl            = '0;
        ctl.take       = in_valid && !in_stall;
        state_next     = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                state_next = S_IDLE;
            end
            S_CHECK:
            begin
                if (st.rpm_ok)
                    state_next = S_RATE;
                else
                begin
                    ctl.period_default = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            S_RATE:
            begin
                state_next = S_RATE_CHK;
            end
            S_RATE_CHK:
            begin
                if (st.rate_zero)
                begin
                    ctl.period_default = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_PERIOD;
                end
            end
            S_PERIOD:
            begin
                if (st.div_done)
                begin
                    ctl.period_quot = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (st.speed_wr)
            state_next = S_CHECK;
        if (ctl.take)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_blocked;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ sv/stepper_pulse_train_generator.sv @@
// Step/direction pulse generator. Each item is a timebase tick, a start-move, a stop or a
// set-position command, and each item gives one result with the step, direction and enable
// line levels, the busy flag and the tracked position. Ticks run at one per cycle while the
// result side keeps up and no period update stalls the input. A write to speed_rpm starts
// a period update: rpm times the motor steps per revolution is divided by 60 with a
// reciprocal multiply over two register stages, and 1000000/rate then runs on a
// shift-subtract divider (one quotient bit per cycle). in_stall is high in the write cycle
// and through the check, rate and divide states (an rpm of zero or above MAX_RPM ends it
// at the check). Writes of driver_enable take effect at once; cfg_ready is always high.
module stepper_pulse_train_generator #(
    parameter int MAX_RPM     = spg_pkg::MAX_RPM_DEFAULT,
    parameter int MOTOR_STEPS = spg_pkg::MOTOR_STEPS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [spg_pkg::CMD_W-1:0]           cmd,
    input  logic signed [spg_pkg::STEPS_W-1:0]  steps,
    input  logic                                direction,
    input  logic signed [spg_pkg::POS_W-1:0]    new_position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                step_level,
    output logic                                dir_level,
    output logic                                enable_level,
    output logic                                busy_res,
    output logic signed [spg_pkg::POS_W-1:0]    position,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spg_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import spg_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    spg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .ctl       (ctl)
    );

    spg_datapath #(
        .MAX_RPM     (MAX_RPM),
        .MOTOR_STEPS (MOTOR_STEPS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .steps        (steps),
        .direction    (direction),
        .new_position (new_position),
        .ctl          (ctl),
        .st           (st),
        .step_level   (step_level),
        .dir_level    (dir_level),
        .enable_level (enable_level),
        .busy_res     (busy_res),
        .position     (position)
    );

endmodule

@@ sv/spg_checker.sv @@
module spg_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic [spg_pkg::CMD_W-1:0]           cmd,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic                                step_level,
    input logic                                dir_level,
    input logic                                busy_res,
    input logic signed [spg_pkg::POS_W-1:0]    position
);
    import spg_pkg::*;

    logic take;

    assign take = in_valid && !in_stall;

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position) && $stable(step_level))
        else $error("stalled result changed");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid)
        else $error("accepted item gave no result");

    a_pos_only_on_item: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(position) && $stable(busy_res) && $stable(dir_level))
        else $error("state moved without an item");

    a_step_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step_level |-> busy_res)
        else $error("step high while idle");

    a_stop_drops: assert property (@(posedge clk) disable iff (!rst_n)
        take && (cmd == CMD_STOP) |=> !busy_res && !step_level)
        else $error("stop did not end the train");

endmodule

bind stepper_pulse_train_generator spg_checker u_spg_checker (.*);
